/* design/muscl_minmod_face_reconstruction_assert.svh */
// Assertion macros shared by the MUSCL face reconstruction RTL.
`ifndef MUSCL_MINMOD_FACE_RECONSTRUCTION_ASSERT_SVH
`define MUSCL_MINMOD_FACE_RECONSTRUCTION_ASSERT_SVH

// Same-cycle implication, clocked on clk and held off during reset.
`define MMFR_ASSERT_IMP(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, clocked on clk and held off during reset.
`define MMFR_ASSERT_NXT(label, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

/* design/mmfr_pkg.sv */
// Package with the lane constants of the MUSCL face reconstruction block.
`default_nettype none

package mmfr_pkg;

    // The four velocity corrections run as lanes through the divider.
    localparam int NUM_LANES    = 4;
    localparam int LANE_MINUS_U = 0;
    localparam int LANE_PLUS_U  = 1;
    localparam int LANE_MINUS_V = 2;
    localparam int LANE_PLUS_V  = 3;

    // Lanes on the minus face, and lanes that carry the y velocity.
    localparam logic [NUM_LANES-1:0] LANE_IS_MINUS = 4'b0101;
    localparam logic [NUM_LANES-1:0] LANE_IS_V     = 4'b1100;

endpackage

`default_nettype wire

/* design/muscl_minmod_face_reconstruction.sv */
// MUSCL minmod face reconstruction: a fully pipelined datapath, one cell per item.
`default_nettype none

// Takes h, u, v and z of three adjacent cells and returns the minus-face and
// plus-face values of the middle cell, saturated to DATA_WIDTH bits. The block
// accepts one item every clock cycle unless out_ready holds the full pipeline,
// and delivers one result per item, in order. An item passes through stages of
// slopes, limiters, face depths and products, then the restoring divider
// (DATA_WIDTH + 1 stages, four lanes side by side), then a stage that clamps the
// quotient and a last stage that adds and saturates into the output register.
// Each stage holds its item while the stage after it is full and stalled, so
// bubbles close up and no item is lost or repeated.

`include "muscl_minmod_face_reconstruction_assert.svh"

module muscl_minmod_face_reconstruction
    import mmfr_pkg::*;
#(
    parameter int DATA_WIDTH = 32
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic signed [DATA_WIDTH-1:0] h_prev,
    input  wire logic signed [DATA_WIDTH-1:0] h_cur,
    input  wire logic signed [DATA_WIDTH-1:0] h_next,
    input  wire logic signed [DATA_WIDTH-1:0] u_prev,
    input  wire logic signed [DATA_WIDTH-1:0] u_cur,
    input  wire logic signed [DATA_WIDTH-1:0] u_next,
    input  wire logic signed [DATA_WIDTH-1:0] v_prev,
    input  wire logic signed [DATA_WIDTH-1:0] v_cur,
    input  wire logic signed [DATA_WIDTH-1:0] v_next,
    input  wire logic signed [DATA_WIDTH-1:0] z_prev,
    input  wire logic signed [DATA_WIDTH-1:0] z_cur,
    input  wire logic signed [DATA_WIDTH-1:0] z_next,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic signed [DATA_WIDTH-1:0]      minus_h,
    output logic signed [DATA_WIDTH-1:0]      minus_u,
    output logic signed [DATA_WIDTH-1:0]      minus_v,
    output logic signed [DATA_WIDTH-1:0]      minus_z,
    output logic signed [DATA_WIDTH-1:0]      plus_h,
    output logic signed [DATA_WIDTH-1:0]      plus_u,
    output logic signed [DATA_WIDTH-1:0]      plus_v,
    output logic signed [DATA_WIDTH-1:0]      plus_z,
    output logic                              dry_flag
);

    localparam int W    = DATA_WIDTH;
    localparam int NQ   = W + 1;
    localparam int NSTG = NQ + 7;
    localparam int ST_F1 = NQ + 5;
    localparam int ST_F2 = NQ + 6;

    localparam logic signed [W+2:0] SAT_HI = {4'b0000, {(W-1){1'b1}}};
    localparam logic signed [W+2:0] SAT_LO = {4'b1111, {(W-1){1'b0}}};
    localparam logic [W:0]          Q_LIM  = {1'b1, {W{1'b0}}};

    // Values that ride alongside the divider.
    typedef struct packed {
        logic signed [W-1:0]  minus_h;
        logic signed [W-1:0]  plus_h;
        logic signed [W-1:0]  minus_z;
        logic signed [W-1:0]  plus_z;
        logic signed [W-1:0]  uc;
        logic signed [W-1:0]  vc;
        logic [W-2:0]         den;
        logic                 dry;
        logic [NUM_LANES-1:0] neg;
    } side_t;

    // Minmod limiter: the smaller magnitude when signs agree, else zero.
    function automatic logic signed [W+1:0] minmod(input logic signed [W+1:0] a,
                                                    input logic signed [W+1:0] b);
        logic signed [W+1:0] r;
        priority if (!a[W+1] && !b[W+1])
        begin
            r = (a <= b) ? a : b;
        end
        else if ((a[W+1] || a == '0) && (b[W+1] || b == '0))
        begin
            r = (a >= b) ? a : b;
        end
        else
        begin
            r = '0;
        end
        return r;
    endfunction

    // Saturation to the signed output range.
    function automatic logic signed [W-1:0] sat(input logic signed [W+2:0] x);
        logic signed [W+2:0] r;
        priority if (x > SAT_HI)
        begin
            r = SAT_HI;
        end
        else if (x < SAT_LO)
        begin
            r = SAT_LO;
        end
        else
        begin
            r = x;
        end
        return r[W-1:0];
    endfunction

    // Handshake: a stage takes new data when it is empty or its item moves on.
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;
    logic [NSTG-1:0] rdy;

    assign rdy[NSTG-1] = !vld_reg[NSTG-1] || out_ready;
    for (genvar i = 0; i < NSTG - 1; i++)
    begin : g_rdy
        assign rdy[i] = !vld_reg[i] || rdy[i+1];
    end

    always_comb
    begin
        vld_next[0] = rdy[0] ? in_valid : vld_reg[0];
        for (int i = 1; i < NSTG; i++)
        begin
            vld_next[i] = rdy[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[NSTG-1];

    // Stage 1: differences of each quantity.
    logic signed [W:0]   s1_dh1_reg, s1_dh2_reg, s1_du1_reg, s1_du2_reg;
    logic signed [W:0]   s1_dv1_reg, s1_dv2_reg, s1_dz1_reg, s1_dz2_reg;
    logic signed [W-1:0] s1_hc_reg, s1_uc_reg, s1_vc_reg, s1_zc_reg;

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            s1_dh1_reg <= h_cur - h_next;
            s1_dh2_reg <= h_prev - h_cur;
            s1_du1_reg <= u_cur - u_next;
            s1_du2_reg <= u_prev - u_cur;
            s1_dv1_reg <= v_cur - v_next;
            s1_dv2_reg <= v_prev - v_cur;
            s1_dz1_reg <= z_cur - z_next;
            s1_dz2_reg <= z_prev - z_cur;
            s1_hc_reg  <= h_cur;
            s1_uc_reg  <= u_cur;
            s1_vc_reg  <= v_cur;
            s1_zc_reg  <= z_cur;
        end
    end

    // Stage 2: limited slopes, and the surface differences for the bed.
    logic signed [W:0]   s2_mh_reg, s2_mu_reg, s2_mv_reg;
    logic signed [W+1:0] s2_zs1_reg, s2_zs2_reg;
    logic signed [W-1:0] s2_hc_reg, s2_uc_reg, s2_vc_reg, s2_zc_reg;
    logic signed [W+1:0] s2_mh_full, s2_mu_full, s2_mv_full;

    always_comb
    begin
        s2_mh_full = minmod(s1_dh1_reg, s1_dh2_reg);
        s2_mu_full = minmod(s1_du1_reg, s1_du2_reg);
        s2_mv_full = minmod(s1_dv1_reg, s1_dv2_reg);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[1])
        begin
            s2_mh_reg  <= s2_mh_full[W:0];
            s2_mu_reg  <= s2_mu_full[W:0];
            s2_mv_reg  <= s2_mv_full[W:0];
            s2_zs1_reg <= s1_dz1_reg + s1_dh1_reg;
            s2_zs2_reg <= s1_dz2_reg + s1_dh2_reg;
            s2_hc_reg  <= s1_hc_reg;
            s2_uc_reg  <= s1_uc_reg;
            s2_vc_reg  <= s1_vc_reg;
            s2_zc_reg  <= s1_zc_reg;
        end
    end

    // Stage 3: half slopes, face depths and the limited surface slope.
    logic signed [W:0]   s3_hu_reg, s3_hv_reg, s3_mh_reg;
    logic signed [W+1:0] s3_fm_reg, s3_fp_reg, s3_mz_reg;
    logic signed [W-1:0] s3_hc_reg, s3_uc_reg, s3_vc_reg, s3_zc_reg;
    logic signed [W:0]   s3_hm;

    assign s3_hm = s2_mh_reg >>> 1;

    always_ff @(posedge clk)
    begin
        if (rdy[2])
        begin
            s3_hu_reg <= s2_mu_reg >>> 1;
            s3_hv_reg <= s2_mv_reg >>> 1;
            s3_mh_reg <= s2_mh_reg;
            s3_fm_reg <= s2_hc_reg - s3_hm;
            s3_fp_reg <= s2_hc_reg + s3_hm;
            s3_mz_reg <= minmod(s2_zs1_reg, s2_zs2_reg);
            s3_hc_reg <= s2_hc_reg;
            s3_uc_reg <= s2_uc_reg;
            s3_vc_reg <= s2_vc_reg;
            s3_zc_reg <= s2_zc_reg;
        end
    end

    // Stage 4: bed term, depth outputs, magnitudes and correction signs.
    logic signed [W+1:0]  s4_zt_reg;
    logic signed [W-1:0]  s4_minus_h_reg, s4_plus_h_reg;
    logic [W-1:0]         s4_mhu_reg, s4_mhv_reg;
    logic [W:0]           s4_mfm_reg, s4_mfp_reg;
    logic [NUM_LANES-1:0] s4_neg_reg;
    logic signed [W-1:0]  s4_hc_reg, s4_uc_reg, s4_vc_reg, s4_zc_reg;
    logic signed [W+2:0]  s4_zdiff, s4_zhalf;
    logic signed [W:0]    s4_hu_neg, s4_hv_neg;
    logic signed [W+1:0]  s4_fm_neg, s4_fp_neg;
    logic [NUM_LANES-1:0] s4_neg;

    always_comb
    begin
        s4_zdiff  = s3_mz_reg - s3_mh_reg;
        s4_zhalf  = s4_zdiff >>> 1;
        s4_hu_neg = -s3_hu_reg;
        s4_hv_neg = -s3_hv_reg;
        s4_fm_neg = -s3_fm_reg;
        s4_fp_neg = -s3_fp_reg;
        for (int l = 0; l < NUM_LANES; l++)
        begin
            s4_neg[l] = (LANE_IS_V[l] ? s3_hv_reg[W] : s3_hu_reg[W])
                      ^ (LANE_IS_MINUS[l] ? s3_fp_reg[W+1] : s3_fm_reg[W+1])
                      ^ LANE_IS_MINUS[l];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[3])
        begin
            s4_zt_reg      <= s4_zhalf[W+1:0];
            s4_minus_h_reg <= sat(s3_fm_reg);
            s4_plus_h_reg  <= sat(s3_fp_reg);
            s4_mhu_reg     <= s3_hu_reg[W] ? s4_hu_neg[W-1:0] : s3_hu_reg[W-1:0];
            s4_mhv_reg     <= s3_hv_reg[W] ? s4_hv_neg[W-1:0] : s3_hv_reg[W-1:0];
            s4_mfm_reg     <= s3_fm_reg[W+1] ? s4_fm_neg[W:0] : s3_fm_reg[W:0];
            s4_mfp_reg     <= s3_fp_reg[W+1] ? s4_fp_neg[W:0] : s3_fp_reg[W:0];
            s4_neg_reg     <= s4_neg;
            s4_hc_reg      <= s3_hc_reg;
            s4_uc_reg      <= s3_uc_reg;
            s4_vc_reg      <= s3_vc_reg;
            s4_zc_reg      <= s3_zc_reg;
        end
    end

    // Stage 5: slope times face depth per lane, bed outputs and dry test.
    logic [2*W-1:0]      s5_prod_reg [NUM_LANES];
    side_t               s5_side_reg;
    logic [2*W:0]        s5_prod_full [NUM_LANES];
    logic signed [W+2:0] s5_zm_full, s5_zp_full;
    side_t               s5_side;

    always_comb
    begin
        for (int l = 0; l < NUM_LANES; l++)
        begin
            s5_prod_full[l] = (LANE_IS_V[l] ? s4_mhv_reg : s4_mhu_reg)
                            * (LANE_IS_MINUS[l] ? s4_mfp_reg : s4_mfm_reg);
        end
        s5_zm_full      = s4_zc_reg - s4_zt_reg;
        s5_zp_full      = s4_zc_reg + s4_zt_reg;
        s5_side.minus_h = s4_minus_h_reg;
        s5_side.plus_h  = s4_plus_h_reg;
        s5_side.minus_z = sat(s5_zm_full);
        s5_side.plus_z  = sat(s5_zp_full);
        s5_side.uc      = s4_uc_reg;
        s5_side.vc      = s4_vc_reg;
        s5_side.den     = s4_hc_reg[W-2:0];
        s5_side.dry     = s4_hc_reg[W-1] || (s4_hc_reg == '0);
        s5_side.neg     = s4_neg_reg;
    end

    always_ff @(posedge clk)
    begin
        if (rdy[4])
        begin
            for (int l = 0; l < NUM_LANES; l++)
            begin
                s5_prod_reg[l] <= s5_prod_full[l][2*W-1:0];
            end
            s5_side_reg <= s5_side;
        end
    end

    // Restoring divider: one quotient bit per stage in each lane. The top
    // product bits start as the remainder; if they already reach the divisor
    // the quotient is out of range and is clamped later.
    logic [W-2:0] div_rem_reg  [1:NQ][NUM_LANES];
    logic [W:0]   div_low_reg  [1:NQ][NUM_LANES];
    logic         div_ovf_reg  [1:NQ][NUM_LANES];
    side_t        div_side_reg [1:NQ];

    for (genvar k = 1; k <= NQ; k++)
    begin : g_div
        side_t src_side;

        if (k == 1)
        begin : g_side_first
            assign src_side = s5_side_reg;
        end
        else
        begin : g_side_next
            assign src_side = div_side_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (rdy[4+k])
            begin
                div_side_reg[k] <= src_side;
            end
        end

        for (genvar l = 0; l < NUM_LANES; l++)
        begin : g_lane
            logic [W-2:0] src_rem;
            logic [W:0]   src_low;
            logic         src_ovf;
            logic [W-1:0] trial;
            logic [W-1:0] diff;
            logic         ge;

            if (k == 1)
            begin : g_src_first
                assign src_rem = s5_prod_reg[l][2*W-1:W+1];
                assign src_low = s5_prod_reg[l][W:0];
                assign src_ovf = (s5_prod_reg[l][2*W-1:W+1] >= s5_side_reg.den);
            end
            else
            begin : g_src_next
                assign src_rem = div_rem_reg[k-1][l];
                assign src_low = div_low_reg[k-1][l];
                assign src_ovf = div_ovf_reg[k-1][l];
            end

            assign trial = {src_rem, src_low[W]};
            assign diff  = trial - {1'b0, src_side.den};
            assign ge    = (trial >= {1'b0, src_side.den});

            always_ff @(posedge clk)
            begin
                if (rdy[4+k])
                begin
                    div_rem_reg[k][l] <= ge ? diff[W-2:0] : trial[W-2:0];
                    div_low_reg[k][l] <= {src_low[W-1:0], ge};
                    div_ovf_reg[k][l] <= src_ovf;
                end
            end
        end
    end

    // Clamp the quotient and give it the sign of the correction.
    logic signed [W+1:0] f1_corr_reg [NUM_LANES];
    side_t               f1_side_reg;
    logic [W:0]          f1_qc [NUM_LANES];
    logic signed [W+1:0] f1_qs [NUM_LANES];

    always_comb
    begin
        for (int l = 0; l < NUM_LANES; l++)
        begin
            f1_qc[l] = (div_ovf_reg[NQ][l] || (div_low_reg[NQ][l] > Q_LIM))
                     ? Q_LIM : div_low_reg[NQ][l];
            f1_qs[l] = $signed({1'b0, f1_qc[l]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[ST_F1])
        begin
            for (int l = 0; l < NUM_LANES; l++)
            begin
                f1_corr_reg[l] <= div_side_reg[NQ].neg[l] ? -f1_qs[l] : f1_qs[l];
            end
            f1_side_reg <= div_side_reg[NQ];
        end
    end

    // Output register: apply the corrections, saturate, pass through when dry.
    logic signed [W-1:0] vel_out_reg [NUM_LANES];
    logic signed [W-1:0] minus_h_reg, plus_h_reg, minus_z_reg, plus_z_reg;
    logic                dry_reg;
    logic signed [W-1:0] f2_cur [NUM_LANES];
    logic signed [W+2:0] f2_sum [NUM_LANES];

    always_comb
    begin
        for (int l = 0; l < NUM_LANES; l++)
        begin
            f2_cur[l] = LANE_IS_V[l] ? f1_side_reg.vc : f1_side_reg.uc;
            f2_sum[l] = f2_cur[l] + f1_corr_reg[l];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[ST_F2])
        begin
            for (int l = 0; l < NUM_LANES; l++)
            begin
                vel_out_reg[l] <= f1_side_reg.dry ? f2_cur[l] : sat(f2_sum[l]);
            end
            minus_h_reg <= f1_side_reg.minus_h;
            plus_h_reg  <= f1_side_reg.plus_h;
            minus_z_reg <= f1_side_reg.minus_z;
            plus_z_reg  <= f1_side_reg.plus_z;
            dry_reg     <= f1_side_reg.dry;
        end
    end

    assign minus_h  = minus_h_reg;
    assign plus_h   = plus_h_reg;
    assign minus_z  = minus_z_reg;
    assign plus_z   = plus_z_reg;
    assign minus_u  = vel_out_reg[LANE_MINUS_U];
    assign plus_u   = vel_out_reg[LANE_PLUS_U];
    assign minus_v  = vel_out_reg[LANE_MINUS_V];
    assign plus_v   = vel_out_reg[LANE_PLUS_V];
    assign dry_flag = dry_reg;

    // Checks on the pipeline and the divider.
    `MMFR_ASSERT_IMP(a_dry_passthrough, out_valid && dry_flag,
        minus_u == plus_u && minus_v == plus_v, "dry cell altered a velocity")
    `MMFR_ASSERT_NXT(a_accept_fills_stage, in_valid && in_ready, vld_reg[0],
        "accepted item did not enter the first stage")
    `MMFR_ASSERT_IMP(a_full_stall_blocks, (&vld_reg) && !out_ready, !in_ready,
        "item accepted into a full stalled pipeline")
    `MMFR_ASSERT_IMP(a_div_remainder,
        vld_reg[NQ+4] && !div_side_reg[NQ].dry
            && !div_ovf_reg[NQ][LANE_MINUS_U] && !div_ovf_reg[NQ][LANE_PLUS_V],
        div_rem_reg[NQ][LANE_MINUS_U] < div_side_reg[NQ].den
            && div_rem_reg[NQ][LANE_PLUS_V] < div_side_reg[NQ].den,
        "divider remainder not below the divisor")

endmodule

`default_nettype wire
